// ===== rtl/core/lva_pkg.sv =====
// shared constants, types and helpers for the lru voice allocator
package lva_pkg;

  localparam int MAX_VOICES = 8;
  localparam int IDX_W      = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CNT_W      = $clog2(MAX_VOICES + 1);

  localparam int FUNC_W   = 2;
  localparam int NOTE_W   = 7;
  localparam int VIDX_W   = 3;
  localparam int VCOUNT_W = 4;

  localparam logic [FUNC_W-1:0] FUNC_NOTE_ON  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_NOTE_OFF = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 2'd2;

  typedef logic [IDX_W-1:0]  voice_idx_t;
  typedef logic [NOTE_W-1:0] note_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NOTE_SCAN,
    ST_FREE_SCAN,
    ST_FIND,
    ST_SHIFT,
    ST_FINISH
  } lva_state_t;

  // initial recency order: front of the list holds the highest voice
  function automatic voice_idx_t init_order(input int pos);
    return IDX_W'(MAX_VOICES - 1 - pos);
  endfunction

endpackage

// ===== rtl/core/lva_if.sv =====
// handshake channels of the lru voice allocator
interface lva_in_if import lva_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [NOTE_W-1:0] note;
  modport source(output valid, func, note, input ready);
  modport sink(input valid, func, note, output ready);
endinterface

interface lva_out_if import lva_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VIDX_W-1:0] voice_index;
  logic              voice_valid;
  modport source(output valid, voice_index, voice_valid, input ready);
  modport sink(input valid, voice_index, voice_valid, output ready);
endinterface

interface lva_cfg_if import lva_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VCOUNT_W-1:0] voice_count;
  modport source(output valid, voice_count, input ready);
  modport sink(input valid, voice_count, output ready);
endinterface

// ===== rtl/core/lru_voice_allocator_core.sv =====
// lru voice allocator: note-on/note-off/clear sequencer over one pool or list entry at a time
//
//  channel  dir  payload                     handshake
//  in_ch    in   func[1:0], note[6:0]        valid/ready
//  out_ch   out  voice_index[2:0], voice_valid  valid/ready
//  cfg_ch   in   voice_count[3:0]            valid/ready, ready always high
//
// one word is accepted, then the pool is scanned for its note and, for a note-on that no
// voice holds, the recency list is scanned for the least recent free voice; a chosen voice
// is then searched for in the recency list and moved to its front, each entry it moves past
// shifting back by one, and the result goes to the output register once that is free.
// all of it runs on one compare per cycle against one pool or list entry.
// clear and unused codes skip the scans. reset is synchronous and restores the pool.
// in_ch is ready only between words; a finished result parks in the output register,
// so the next word may start while the previous result waits.
module lru_voice_allocator_core import lva_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  lva_in_if.sink    in_ch,
  lva_out_if.source out_ch,
  lva_cfg_if.sink   cfg_ch
);

  lva_state_t          state_r, state_nxt;
  logic [FUNC_W-1:0]   func_r, func_nxt;
  note_t               note_r, note_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  voice_idx_t          idx_r, idx_nxt;
  voice_idx_t          vsel_r, vsel_nxt;
  voice_idx_t          fb_r, fb_nxt;
  logic                found_r, found_nxt;
  logic                free_found_r, free_found_nxt;
  logic                res_valid_r, res_valid_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [VIDX_W-1:0]   out_index_r, out_index_nxt;
  logic                out_vv_r, out_vv_nxt;
  logic [VCOUNT_W-1:0] voice_count_r;

  note_t               voice_note_r [MAX_VOICES];
  note_t               voice_note_nxt [MAX_VOICES];
  logic [MAX_VOICES-1:0] voice_active_r, voice_active_nxt;
  voice_idx_t          recency_r [MAX_VOICES];
  voice_idx_t          recency_nxt [MAX_VOICES];

  logic [CNT_W-1:0]    n_cur;
  voice_idx_t          rd_addr;
  voice_idx_t          rec_c;
  logic                note_hit;
  logic                rec_en;
  logic                free_hit;
  logic                last;
  logic                hit_any;
  logic                free_any;
  voice_idx_t          fb_v;
  voice_idx_t          free_v;
  logic [MAX_VOICES-1:0] perm_mask;

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.voice_index = out_index_r;
  assign out_ch.voice_valid = out_vv_r;

  always_comb begin
    if (int'(voice_count_r) > MAX_VOICES) begin
      n_cur = CNT_W'(MAX_VOICES);
    end else begin
      n_cur = CNT_W'(voice_count_r);
    end
  end

  // single list read port, one entry behind during the shift
  assign rd_addr  = (state_r == ST_SHIFT) ? idx_r - 1'b1 : idx_r;
  assign rec_c    = recency_r[rd_addr];
  assign last     = (idx_r == IDX_W'(MAX_VOICES - 1));
  assign note_hit = (voice_note_r[idx_r] == note_r) && (CNT_W'(idx_r) < n_r);
  assign rec_en   = (CNT_W'(rec_c) < n_r);
  assign free_hit = rec_en && !voice_active_r[rec_c];
  assign hit_any  = found_r || note_hit;
  assign free_any = free_found_r || free_hit;
  assign fb_v     = rec_en ? rec_c : fb_r;
  assign free_v   = free_hit ? rec_c : vsel_r;

  always_comb begin
    perm_mask = '0;
    for (int i = 0; i < MAX_VOICES; i++) begin
      perm_mask[recency_r[i]] = 1'b1;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    func_nxt         = func_r;
    note_nxt         = note_r;
    n_nxt            = n_r;
    idx_nxt          = idx_r;
    vsel_nxt         = vsel_r;
    fb_nxt           = fb_r;
    found_nxt        = found_r;
    free_found_nxt   = free_found_r;
    res_valid_nxt    = res_valid_r;
    out_valid_nxt    = out_valid_r;
    out_index_nxt    = out_index_r;
    out_vv_nxt       = out_vv_r;
    voice_note_nxt   = voice_note_r;
    voice_active_nxt = voice_active_r;
    recency_nxt      = recency_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          func_nxt       = in_ch.func;
          note_nxt       = in_ch.note;
          n_nxt          = n_cur;
          idx_nxt        = '0;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          res_valid_nxt  = 1'b0;
          state_nxt      = ST_FINISH;
          unique case (in_ch.func)
            FUNC_NOTE_ON, FUNC_NOTE_OFF: begin
              if (n_cur != '0) begin
                state_nxt = ST_NOTE_SCAN;
              end
            end
            FUNC_CLEAR: begin
              voice_active_nxt = '0;
              for (int i = 0; i < MAX_VOICES; i++) begin
                voice_note_nxt[i] = '0;
                recency_nxt[i]    = init_order(i);
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_NOTE_SCAN: begin
        // note-on keeps the first holder, note-off the last
        if (note_hit && (func_r == FUNC_NOTE_OFF || !found_r)) begin
          vsel_nxt  = idx_r;
          found_nxt = 1'b1;
        end
        if (last) begin
          idx_nxt = '0;
          if (hit_any) begin
            state_nxt = ST_FIND;
          end else if (func_r == FUNC_NOTE_ON) begin
            state_nxt = ST_FREE_SCAN;
          end else begin
            res_valid_nxt = 1'b0;
            state_nxt     = ST_FINISH;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_FREE_SCAN: begin
        // walking front to back, the last enabled hit is the least recent
        fb_nxt         = fb_v;
        vsel_nxt       = free_v;
        free_found_nxt = free_any;
        if (last) begin
          vsel_nxt  = free_any ? free_v : fb_v;
          idx_nxt   = '0;
          state_nxt = ST_FIND;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_FIND: begin
        if (rec_c == vsel_r || last) begin
          if (func_r == FUNC_NOTE_ON) begin
            voice_note_nxt[vsel_r]   = note_r;
            voice_active_nxt[vsel_r] = 1'b1;
          end else begin
            voice_active_nxt[vsel_r] = 1'b0;
          end
          state_nxt = ST_SHIFT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_SHIFT: begin
        if (idx_r == '0) begin
          recency_nxt[0] = vsel_r;
          res_valid_nxt  = 1'b1;
          state_nxt      = ST_FINISH;
        end else begin
          recency_nxt[idx_r] = rec_c;
          idx_nxt            = idx_r - 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = res_valid_r ? VIDX_W'(vsel_r) : '0;
          out_vv_nxt    = res_valid_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      voice_active_r <= '0;
      for (int i = 0; i < MAX_VOICES; i++) begin
        voice_note_r[i] <= '0;
        recency_r[i]    <= init_order(i);
      end
    end else begin
      state_r        <= state_nxt;
      out_valid_r    <= out_valid_nxt;
      voice_active_r <= voice_active_nxt;
      voice_note_r   <= voice_note_nxt;
      recency_r      <= recency_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    note_r       <= note_nxt;
    n_r          <= n_nxt;
    idx_r        <= idx_nxt;
    vsel_r       <= vsel_nxt;
    fb_r         <= fb_nxt;
    found_r      <= found_nxt;
    free_found_r <= free_found_nxt;
    res_valid_r  <= res_valid_nxt;
    out_index_r  <= out_index_nxt;
    out_vv_r     <= out_vv_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voice_count_r <= '0;
    end else if (cfg_ch.valid) begin
      voice_count_r <= cfg_ch.voice_count;
    end
  end

  // a miss always reports voice zero
  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_vv_r |-> out_index_r == '0)
    else $error("miss result carries a nonzero voice index");

  // between words the recency list is a permutation of the voices
  a_list_is_perm: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> &perm_mask)
    else $error("recency list lost or duplicated a voice");

  // a clear word empties the pool at once
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.func == FUNC_CLEAR
      |=> voice_active_r == '0 && state_r == ST_FINISH)
    else $error("clear did not release all voices");

endmodule

// ===== sim/tb_lru_voice_allocator_core.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the lru voice allocator core with a shadow voice pool
module tb_lru_voice_allocator_core;
  import lva_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES        = 14;
  localparam int PHASE_WORDS   = 140;
  localparam int PHASE_VC [PHASES] = '{8, 1, 15, 4, 8, 2, 9, 6, 0, 8, 3, 7, 5, 8};

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    note_t             note;
    logic              drain_first;
  } alloc_word_t;

  typedef struct packed {
    logic [VIDX_W-1:0] voice_index;
    logic              voice_valid;
  } alloc_result_t;

  logic clk;
  logic rst_n;

  lva_in_if  in_ch();
  lva_out_if out_ch();
  lva_cfg_if cfg_ch();

  lru_voice_allocator_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  alloc_word_t   word_q[$];
  alloc_result_t alloc_q[$];
  int mismatch_count = 0;
  int queued_words   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  note_t hot_notes [12];

  // shadow copy of the voice pool
  logic [VCOUNT_W-1:0] model_count;
  note_t               pool_note   [MAX_VOICES];
  logic                pool_active [MAX_VOICES];
  voice_idx_t          lru_list    [MAX_VOICES];

  function automatic void clear_pool();
    for (int i = 0; i < MAX_VOICES; i++) begin
      pool_note[i]   = '0;
      pool_active[i] = 1'b0;
      lru_list[i]    = voice_idx_t'(MAX_VOICES - 1 - i);
    end
  endfunction

  function automatic void move_to_front(input int v);
    int p = 0;
    for (int i = 0; i < MAX_VOICES; i++)
      if (lru_list[i] == v) p = i;
    for (int i = p; i > 0; i--)
      lru_list[i] = lru_list[i-1];
    lru_list[0] = voice_idx_t'(v);
  endfunction

  function automatic alloc_result_t allocate(input logic [FUNC_W-1:0] f, input note_t nt);
    int n;
    int v;
    int c;
    alloc_result_t r;
    n = (model_count > MAX_VOICES) ? MAX_VOICES : int'(model_count);
    v = -1;
    case (f)
      FUNC_NOTE_ON: begin
        if (n > 0) begin
          for (int i = 0; i < n; i++)
            if (v < 0 && pool_note[i] == nt) v = i;
          // last hit in the list is the least recently touched
          if (v < 0)
            for (int i = 0; i < MAX_VOICES; i++) begin
              c = lru_list[i];
              if (c < n && !pool_active[c]) v = c;
            end
          if (v < 0)
            for (int i = 0; i < MAX_VOICES; i++) begin
              c = lru_list[i];
              if (c < n) v = c;
            end
          pool_note[v]   = nt;
          pool_active[v] = 1'b1;
          move_to_front(v);
        end
      end
      FUNC_NOTE_OFF: begin
        for (int i = 0; i < n; i++)
          if (pool_note[i] == nt) v = i;
        if (v >= 0) begin
          pool_active[v] = 1'b0;
          move_to_front(v);
        end
      end
      FUNC_CLEAR: clear_pool();
      default: ;
    endcase
    r.voice_valid = (v >= 0);
    r.voice_index = (v >= 0) ? VIDX_W'(v) : '0;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  function automatic void push_word(input logic [FUNC_W-1:0] f, input note_t nt,
                                    input logic drain);
    alloc_word_t w;
    w.func        = f;
    w.note        = nt;
    w.drain_first = drain || ($urandom_range(149) == 0);
    word_q.push_back(w);
    queued_words++;
  endfunction

  task automatic gen_random(input int count, input logic drain_start);
    int start;
    int kind;
    int m;
    int k;
    note_t held[$];
    note_t nt;
    start = queued_words;
    for (int i = 0; i < 12; i++) hot_notes[i] = note_t'($urandom_range(127));
    if ($urandom_range(1)) hot_notes[0] = '0;
    if ($urandom_range(1)) hot_notes[11] = '1;
    if (drain_start) push_word(FUNC_NOTE_ON, hot_notes[0], 1'b1);
    while (queued_words - start < count) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        // chord: note-ons, then most of the note-offs in random order
        m = $urandom_range(1, 10);
        held.delete();
        for (int i = 0; i < m; i++) begin
          nt = ($urandom_range(3) == 0) ? note_t'($urandom_range(127))
                                        : hot_notes[$urandom_range(11)];
          held.push_back(nt);
          push_word(FUNC_NOTE_ON, nt, 1'b0);
        end
        while (held.size() > 0) begin
          k = $urandom_range(held.size() - 1);
          if ($urandom_range(9) != 0) push_word(FUNC_NOTE_OFF, held[k], 1'b0);
          held.delete(k);
        end
      end else if (kind < 86) begin
        push_word(FUNC_W'($urandom_range(3)), note_t'($urandom_range(127)), 1'b0);
      end else if (kind < 90) begin
        push_word(FUNC_CLEAR, note_t'($urandom_range(127)), 1'b0);
      end else begin
        push_word(FUNC_NOTE_OFF, hot_notes[$urandom_range(11)], 1'b0);
      end
    end
  endtask

  task automatic wait_idle();
    while (word_q.size() != 0 || alloc_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_voice_count(input logic [VCOUNT_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.voice_count <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    model_count = val;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        alloc_q.push_back(allocate(in_ch.func, in_ch.note));
        void'(word_q.pop_front());
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the word until taken
      end else if (word_q.size() > 0 && !(word_q[0].drain_first && alloc_q.size() != 0) &&
                   $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.func  <= word_q[0].func;
        in_ch.note  <= word_q[0].note;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result monitor
  always @(posedge clk) begin
    alloc_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (alloc_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word: voice_index %0d voice_valid %0d",
                                  out_ch.voice_index, out_ch.voice_valid));
      end else begin
        want = alloc_q.pop_front();
        if (out_ch.voice_index !== want.voice_index)
          report_mismatch($sformatf("voice_index got %0d want %0d",
                                    out_ch.voice_index, want.voice_index));
        if (out_ch.voice_valid !== want.voice_valid)
          report_mismatch($sformatf("voice_valid got %0d want %0d",
                                    out_ch.voice_valid, want.voice_valid));
      end
    end
  end

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.func         = FUNC_NOTE_ON;
    in_ch.note         = '0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.voice_count = '0;
    model_count        = '0;
    clear_pool();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // nothing enabled after reset
    @(negedge clk);
    push_word(FUNC_NOTE_ON, 7'd60, 1'b0);
    push_word(FUNC_NOTE_OFF, 7'd60, 1'b0);
    push_word(FUNC_UNUSED, 7'd127, 1'b0);
    push_word(FUNC_CLEAR, 7'd0, 1'b0);
    wait_idle();

    write_voice_count(4'd8);
    @(negedge clk);
    push_word(FUNC_NOTE_ON, 7'd0, 1'b0);    // cleared voice already holds note 0
    push_word(FUNC_NOTE_ON, 7'd127, 1'b0);
    for (int i = 10; i < 16; i++) push_word(FUNC_NOTE_ON, note_t'(i), 1'b0);
    push_word(FUNC_NOTE_ON, 7'd20, 1'b0);   // pool full, steal oldest
    push_word(FUNC_NOTE_OFF, 7'd127, 1'b0);
    push_word(FUNC_NOTE_OFF, 7'd99, 1'b0);  // note not held
    push_word(FUNC_NOTE_ON, 7'd20, 1'b0);
    push_word(FUNC_UNUSED, 7'd127, 1'b0);
    push_word(FUNC_CLEAR, 7'd127, 1'b0);
    push_word(FUNC_NOTE_ON, 7'd0, 1'b0);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      write_voice_count(VCOUNT_W'(PHASE_VC[p]));
      @(negedge clk);
      gen_random((PHASE_VC[p] == 0) ? 30 : PHASE_WORDS, p == 2);
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
